// File: hw/rtl/utf8_token_budget_truncator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the token budget truncator
// Concurrent checks on clk_i, disabled while rst_ni is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_TOKEN_BUDGET_TRUNCATOR_ASSERT_SVH
`define UTF8_TOKEN_BUDGET_TRUNCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// plain property, checked every clock
`define UTB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// same-cycle implication
`define UTB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define UTB_ASSERT(lbl, prop, msg)
`define UTB_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: hw/rtl/utb_pkg.sv
// ----------------------------------------------------------------------------
// utb_pkg
// Types, constants and helpers shared by the token budget truncator.
// ----------------------------------------------------------------------------
`default_nettype none

package utb_pkg;

  localparam int unsigned MaxBytes       = 65536;
  localparam int unsigned ReservedTokens = 3;

  localparam int unsigned CntW  = 17;  // token counts, byte positions
  localparam int unsigned PosW  = 16;  // positions of bytes below the limit
  localparam int unsigned WordW = 15;  // per-word token count
  localparam int unsigned SeqW  = 15;  // sequence length register

  localparam logic [WordW-1:0] WordSat = '1;

  localparam logic [7:0] ByteCont    = 8'h80;  // 10xxxxxx
  localparam logic [7:0] ByteTopMask = 8'hC0;
  localparam logic [7:0] LeadThree   = 8'hE0;
  localparam logic [7:0] LeadFour    = 8'hF0;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChCr        = 8'h0D;

  typedef enum logic [1:0] {
    OP_QUERY_BYTE   = 2'd0,
    OP_QUERY_END    = 2'd1,
    OP_PASSAGE_BYTE = 2'd2,
    OP_PASSAGE_END  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CAT_NORMAL    = 2'd0,
    CAT_TRUNCATED = 2'd1,
    CAT_EXTREME   = 2'd2
  } category_e;

  // per-text counting state
  typedef struct packed {
    logic [CntW-1:0]  token_total;
    logic [WordW-1:0] word_tokens;
    logic [1:0]       word_phase;
    logic             in_word;
    logic [PosW-1:0]  word_base;
    logic [1:0]       skip_left;
    logic [CntW-1:0]  byte_pos;
    logic [PosW-1:0]  last_whole_pos;
    logic             cut_found;
    logic [CntW-1:0]  cut_pos;
  } text_t;

  function automatic logic [CntW-1:0] sat_cnt(input logic [CntW:0] s);
    return s[CntW] ? {CntW{1'b1}} : s[CntW-1:0];
  endfunction

  // closes the open ASCII word, recording the first cut on a passage
  function automatic text_t close_word(input text_t t, input logic passage,
                                       input logic [SeqW-1:0] bud);
    text_t         r;
    logic [CntW:0] sum;
    r   = t;
    sum = {1'b0, t.token_total} + (CntW+1)'(t.word_tokens);
    if (t.in_word) begin
      if (passage && !t.cut_found && sum > (CntW+1)'(bud)) begin
        r.cut_found = 1'b1;
        r.cut_pos   = CntW'(t.word_base);
      end
      r.token_total = sat_cnt(sum);
    end
    r.in_word     = 1'b0;
    r.word_tokens = '0;
    r.word_phase  = '0;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/utf8_token_budget_truncator.sv
// ----------------------------------------------------------------------------
// utf8_token_budget_truncator
// Token estimate of a query and a passage, and the passage prefix to keep.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per byte or end
//   marker: query bytes, query end, passage bytes, passage end.
//   Output channel (out_valid_o/out_ready_i) carries one result item per
//   passage end: category, both token counts, kept length and flags.
//   cfg_we_i/cfg_wdata_i write the sequence length, only while the block is idle;
//   the user must ensure it, the block does not enforce it. The result register
//   loads at the edge the passage end item is taken, so the result can be
//   taken in the next cycle. Throughput: one item per cycle, every opcode,
//   unless stalled; the counting state is updated at the edge an item is
//   taken, by a single pass of logic (word close, segment add, budget compare).
//   Stall: while a result waits unclaimed, in_ready_o follows out_ready_i,
//   so a new item still enters in the cycle the waiting result is taken.
//   Reset: counting state clears, no result pending, sequence length = 512.
//   After each result the text state clears; the register keeps its value.
// ----------------------------------------------------------------------------
`default_nettype none
`include "utf8_token_budget_truncator_assert.svh"

module utf8_token_budget_truncator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [utb_pkg::SeqW-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 opcode_i,
  input  logic [7:0]                 text_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 category_o,
  output logic [utb_pkg::CntW-1:0]   passage_tokens_o,
  output logic [utb_pkg::CntW-1:0]   query_tokens_o,
  output logic [utb_pkg::CntW-1:0]   kept_length_o,
  output logic                       score_zero_o,
  output logic                       too_long_o
);
  import utb_pkg::*;

  // state
  logic [SeqW-1:0] max_q;
  text_t           text_q, text_d;
  logic [CntW-1:0] query_count_q, query_count_d;
  logic            overflow_q, overflow_d;
  logic            passage_open_q, passage_open_d;

  // result register
  logic            out_valid_q, out_valid_d;
  category_e       category_q, category_d;
  logic [CntW-1:0] ptok_q, ptok_d;
  logic [CntW-1:0] qtok_q, qtok_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic            too_long_q, too_long_d;

  logic            accept;
  opcode_e         op;
  logic [CntW:0]   q_sum;
  logic [CntW-1:0] q_close;
  logic            closing;
  text_t           text_pre;
  logic [CntW-1:0] qc_eff;
  logic [CntW:0]   need;
  logic [SeqW-1:0] budget;
  text_t           feed_in;
  text_t           feed_out;
  logic            feed_ovf;
  logic            feed_psg;
  text_t           closed;
  logic [CntW-1:0] p_tok;
  logic [CntW-1:0] limit4;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = opcode_e'(opcode_i);

  // closing the query: flush the open word, non-empty text counts at least 1
  assign q_sum   = {1'b0, text_q.token_total}
                 + (text_q.in_word ? (CntW+1)'(text_q.word_tokens) : '0);
  assign q_close = (text_q.byte_pos != '0 && sat_cnt(q_sum) == '0) ? CntW'(1)
                                                                     : sat_cnt(q_sum);

  // passage traffic with query bytes pending closes the query on the way
  assign closing  = !passage_open_q && (text_q.byte_pos != '0);
  assign text_pre = closing ? text_t'('0) : text_q;
  assign qc_eff   = closing ? q_close : query_count_q;

  // budget = max(0, sequence length - query - reserved)
  assign need   = (CntW+1)'(qc_eff) + (CntW+1)'(ReservedTokens);
  assign budget = ((CntW+1)'(max_q) > need) ? SeqW'((CntW+1)'(max_q) - need) : '0;

  assign feed_psg = (op == OP_PASSAGE_BYTE);
  assign feed_in  = feed_psg ? text_pre : text_q;

  utb_feed u_feed (
    .text_i     (feed_in),
    .byte_i     (text_byte_i),
    .passage_i  (feed_psg),
    .budget_i   (budget),
    .text_o     (feed_out),
    .overflow_o (feed_ovf)
  );

  // passage end: close the last word and form the result
  assign closed = close_word(text_pre, 1'b1, budget);
  assign p_tok  = (text_pre.byte_pos != '0 && closed.token_total == '0) ? CntW'(1)
                                                                        : closed.token_total;
  assign limit4 = {max_q, 2'b00};

  always_comb begin
    text_d         = text_q;
    query_count_d  = query_count_q;
    overflow_d     = overflow_q;
    passage_open_d = passage_open_q;
    if (accept) begin
      case (op)
        OP_QUERY_BYTE: begin
          if (!passage_open_q) begin
            text_d     = feed_out;
            overflow_d = overflow_q | feed_ovf;
          end
        end
        OP_QUERY_END: begin
          if (!passage_open_q) begin
            query_count_d = q_close;
            text_d        = '0;
          end
        end
        OP_PASSAGE_BYTE: begin
          query_count_d  = qc_eff;
          passage_open_d = 1'b1;
          text_d         = feed_out;
          overflow_d     = overflow_q | feed_ovf;
        end
        OP_PASSAGE_END: begin
          text_d         = '0;
          query_count_d  = '0;
          overflow_d     = 1'b0;
          passage_open_d = 1'b0;
        end
        default: begin
          text_d = text_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    category_d  = category_q;
    ptok_d      = ptok_q;
    qtok_d      = qtok_q;
    kept_d      = kept_q;
    too_long_d  = too_long_q;
    if (accept && op == OP_PASSAGE_END) begin
      out_valid_d = 1'b1;
      ptok_d      = p_tok;
      qtok_d      = qc_eff;
      too_long_d  = overflow_q;
      if (p_tok <= CntW'(budget)) begin
        category_d = CAT_NORMAL;
        kept_d     = text_pre.byte_pos;
      end else if (p_tok > limit4) begin
        category_d = CAT_EXTREME;
        kept_d     = '0;
      end else begin
        category_d = CAT_TRUNCATED;
        if (budget == '0) begin
          kept_d = '0;
        end else if (closed.cut_found) begin
          kept_d = closed.cut_pos;
        end else begin
          kept_d = text_pre.byte_pos;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q          <= SeqW'(512);
      text_q         <= '0;
      query_count_q  <= '0;
      overflow_q     <= 1'b0;
      passage_open_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      text_q         <= text_d;
      query_count_q  <= query_count_d;
      overflow_q     <= overflow_d;
      passage_open_q <= passage_open_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    category_q <= category_d;
    ptok_q     <= ptok_d;
    qtok_q     <= qtok_d;
    kept_q     <= kept_d;
    too_long_q <= too_long_d;
  end

  assign out_valid_o      = out_valid_q;
  assign category_o       = category_q;
  assign passage_tokens_o = ptok_q;
  assign query_tokens_o   = qtok_q;
  assign kept_length_o    = kept_q;
  assign score_zero_o     = (category_q == CAT_EXTREME);
  assign too_long_o       = too_long_q;

  // checks
  `UTB_ASSERT(a_pos_bound, text_q.byte_pos <= CntW'(MaxBytes), "byte position past limit")
  `UTB_ASSERT_IMP(a_cut_in_psg, text_q.cut_found, passage_open_q, "cut outside a passage")
  `UTB_ASSERT_IMP(a_close_gives_result, $fell(passage_open_q), out_valid_q,
                  "passage closed without a result")
  `UTB_ASSERT_IMP(a_extreme_keeps_none, out_valid_q && category_q == CAT_EXTREME,
                  kept_q == '0, "extremely long passage keeps bytes")
  `UTB_ASSERT_IMP(a_kept_in_text, out_valid_q && category_q != CAT_EXTREME,
                  kept_q <= CntW'(MaxBytes), "kept length beyond text")

endmodule

`default_nettype wire

// File: hw/rtl/utb_feed.sv
// ----------------------------------------------------------------------------
// utb_feed
// One text byte into the counting state: words, multibyte leads, cut search.
// ----------------------------------------------------------------------------
`default_nettype none

module utb_feed (
  input  utb_pkg::text_t             text_i,
  input  logic [7:0]                 byte_i,
  input  logic                       passage_i,
  input  logic [utb_pkg::SeqW-1:0]   budget_i,
  output utb_pkg::text_t             text_o,
  output logic                       overflow_o
);
  import utb_pkg::*;

  logic [PosW-1:0] pos;
  logic            is_cont;
  logic [1:0]      seg;
  logic [PosW-1:0] seg_base;
  logic [CntW:0]   seg_sum;
  text_t           t;

  assign pos     = text_i.byte_pos[PosW-1:0];
  assign is_cont = (byte_i & ByteTopMask) == ByteCont;

  always_comb begin
    t          = text_i;
    overflow_o = 1'b0;
    seg        = (byte_i >= LeadThree) ? 2'd2 : 2'd1;
    seg_base   = is_cont ? text_i.last_whole_pos : pos;
    seg_sum    = '0;
    if (text_i.byte_pos >= CntW'(MaxBytes)) begin
      overflow_o = 1'b1;
    end else begin
      if (text_i.skip_left != 2'd0) begin
        t.skip_left = text_i.skip_left - 2'd1;
      end else if (!byte_i[7]) begin
        if (byte_i inside {ChSpace, ChTab, ChLf, ChCr}) begin
          t = close_word(text_i, passage_i, budget_i);
        end else begin
          if (!text_i.in_word) begin
            t.in_word     = 1'b1;
            t.word_base   = pos;
            t.word_tokens = '0;
            t.word_phase  = '0;
          end
          // one token per three bytes, counted on the first of each three
          if (t.word_phase == 2'd0 && t.word_tokens != WordSat) begin
            t.word_tokens = t.word_tokens + WordW'(1);
          end
          t.word_phase = (t.word_phase >= 2'd2) ? 2'd0 : t.word_phase + 2'd1;
        end
      end else begin
        t       = close_word(text_i, passage_i, budget_i);
        seg_sum = {1'b0, t.token_total} + (CntW+1)'(seg);
        if (passage_i && !t.cut_found && seg_sum > (CntW+1)'(budget_i)) begin
          t.cut_found = 1'b1;
          t.cut_pos   = CntW'(seg_base);
        end
        t.token_total = sat_cnt(seg_sum);
        t.skip_left   = (byte_i >= LeadFour)  ? 2'd3 :
                        (byte_i >= LeadThree) ? 2'd2 : 2'd1;
      end
      if (!is_cont) begin
        t.last_whole_pos = pos;
      end
      t.byte_pos = text_i.byte_pos + CntW'(1);
    end
  end

  assign text_o = t;

endmodule

`default_nettype wire
